// ===== sv/source_line_style_checker_defines.svh =====
// ---------------------------------------------------------------------------
// Source line style checker assertion macros
// Shared concurrent assertion forms, sampled on clk and quiet during rst.
// ---------------------------------------------------------------------------
`ifndef SOURCE_LINE_STYLE_CHECKER_DEFINES_SVH
`define SOURCE_LINE_STYLE_CHECKER_DEFINES_SVH

// Same-cycle implication
`define SLSC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("source line style checker: same-cycle check failed");

// Next-cycle implication
`define SLSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("source line style checker: next-cycle check failed");

`endif

// ===== sv/slsc_pkg.sv =====
// ---------------------------------------------------------------------------
// Source line style checker package
// Word types, configuration register indexes, character codes and defaults.
// ---------------------------------------------------------------------------
package slsc_pkg;

  // Default widths of the column and line counters
  localparam int COLUMN_BITS_DEF = 16;
  localparam int LINE_BITS_DEF   = 20;

  // Configuration port
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_RULE_ENABLE   = 2'd0,
    CFG_INDENT_SPACES = 2'd1,
    CFG_MAX_LINE      = 2'd2
  } cfg_index_t;

  // Register reset values and fallbacks for a zero setting
  localparam logic [3:0]  RULE_ENABLE_RST = 4'hF;
  localparam logic [4:0]  DEF_INDENT      = 5'd2;
  localparam logic [15:0] DEF_MAX_LINE    = 16'd120;

  // Rule enable bits
  localparam int RULE_TRAILING = 0;
  localparam int RULE_TABS     = 1;
  localparam int RULE_INDENT   = 2;
  localparam int RULE_LENGTH   = 3;

  // Character codes
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_NL    = 8'd10;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_SPACE = 8'd32;

  // Saturation limit of the per-line issue sum
  localparam logic [17:0] LINE_ISSUES_MAX = 18'h3FFFF;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_end;
  } text_in_t;

  typedef struct packed {
    logic [19:0] line_number;
    logic        trailing_found;
    logic [16:0] trailing_column;
    logic [15:0] leading_tab_count;
    logic        indent_misaligned;
    logic [15:0] tab_count;
    logic        line_too_long;
    logic [17:0] line_issues;
    logic [31:0] total_issues;
    logic        final_line;
  } line_report_t;

endpackage

// ===== sv/source_line_style_checker.sv =====
// ---------------------------------------------------------------------------
// Source line style checker
// Scans source text a byte per word and reports a style summary per line.
// ---------------------------------------------------------------------------
//
//  port group | direction | handshake            | word
//  -----------+-----------+----------------------+------------------------
//  in_*       | input     | in_valid / in_ready  | slsc_pkg::text_in_t
//  out_*      | output    | out_valid / out_ready| slsc_pkg::line_report_t
//  cfg_*      | input     | cfg_write            | cfg_index, cfg_data
//
// One word per cycle while no closing word is stalled; each byte passes through the input register.
// A closing word (newline or end) leaves its report in the output register
// the cycle after it is processed; other bytes keep flowing while it waits.
// A closing word stalls in the input register only while a report is unread.
// rst is synchronous: line state, line number, issue total and registers reset.
// ---------------------------------------------------------------------------
`include "source_line_style_checker_defines.svh"

module source_line_style_checker #(
  parameter int COLUMN_BITS = slsc_pkg::COLUMN_BITS_DEF,
  parameter int LINE_BITS   = slsc_pkg::LINE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  slsc_pkg::text_in_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output slsc_pkg::line_report_t               out_data,
  input  logic                                 cfg_write,
  input  logic [slsc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [slsc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int CB  = COLUMN_BITS;
  localparam int LB  = LINE_BITS;
  localparam int W16 = (CB > 16) ? CB : 16;
  localparam int W17 = (CB + 1 > 17) ? CB + 1 : 17;
  localparam int WS  = (CB + 2 > 18) ? CB + 2 : 18;
  localparam int WL  = (LB > 20) ? LB : 20;

  typedef struct packed {
    logic [CB-1:0] line_length;
    logic [CB-1:0] space_run_length;
    logic [CB-1:0] space_run_tabs;
    logic [CB-1:0] committed_tabs;
    logic [CB-1:0] leading_length;
    logic [CB-1:0] leading_tabs;
    logic [4:0]    indent_residue;
    logic          content_seen;
    logic          pending_return;
  } line_st_t;

  // Saturating column increment
  function automatic logic [CB-1:0] col_inc(input logic [CB-1:0] v);
    return (v == '1) ? v : v + CB'(1);
  endfunction

  // Saturating column add
  function automatic logic [CB-1:0] col_add(input logic [CB-1:0] a, input logic [CB-1:0] b);
    logic [CB:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CB] ? '1 : s[CB-1:0];
  endfunction

  // Fold one ordinary character into the line state
  function automatic line_st_t take_char(input line_st_t s, input logic [7:0] c,
                                         input logic [4:0] width);
    line_st_t   r;
    logic [5:0] n;
    r = s;
    n = {1'b0, s.indent_residue} + 6'd1;
    r.line_length = col_inc(s.line_length);
    if (c == slsc_pkg::CHAR_SPACE || c == slsc_pkg::CHAR_TAB) begin
      r.space_run_length = col_inc(s.space_run_length);
      if (c == slsc_pkg::CHAR_TAB) begin
        r.space_run_tabs = col_inc(s.space_run_tabs);
      end
      if (!s.content_seen) begin
        r.indent_residue = (n >= {1'b0, width}) ? 5'd0 : n[4:0];
      end
    end else begin
      if (!s.content_seen) begin
        r.leading_length = s.space_run_length;
        r.leading_tabs   = s.space_run_tabs;
        r.content_seen   = 1'b1;
      end
      r.committed_tabs   = col_add(s.committed_tabs, s.space_run_tabs);
      r.space_run_length = '0;
      r.space_run_tabs   = '0;
    end
    return r;
  endfunction

  // Configuration registers
  logic [3:0]  rule_enable;
  logic [4:0]  indent_spaces;
  logic [15:0] max_line;

  // Input register
  logic               s1_valid;
  slsc_pkg::text_in_t s1_word;

  // Per-text state
  line_st_t      st;
  line_st_t      st_next;
  logic [LB-1:0] line_count;
  logic [31:0]   issue_total;
  logic [31:0]   issue_total_next;

  logic                   s1_closes;
  logic                   out_free;
  logic                   fire;
  slsc_pkg::line_report_t report;

  // Close-of-line datapath
  logic [4:0]     width;
  logic [15:0]    maxl;
  logic           tabs_on;
  logic           trail;
  logic           mis;
  logic           longl;
  logic [CB-1:0]  keep;
  logic [CB-1:0]  ltabs;
  logic [CB-1:0]  tabs;
  logic [W17-1:0] tcol_w;
  logic [W16-1:0] ltabs_w;
  logic [W16-1:0] tabs_w;
  logic [W16-1:0] len_w;
  logic [W16-1:0] maxl_w;
  logic [WS-1:0]  sum_w;
  logic [17:0]    sum;
  logic [32:0]    total_w;
  logic [WL-1:0]  line_w;
  line_st_t       st_cr;

  assign s1_closes = s1_word.text_end || (s1_word.text_byte == slsc_pkg::CHAR_NL);
  assign out_free  = !out_valid || out_ready;
  assign fire      = s1_valid && (!s1_closes || out_free);
  assign in_ready  = !s1_valid || fire;

  assign width   = (indent_spaces == 5'd0) ? slsc_pkg::DEF_INDENT : indent_spaces;
  assign maxl    = (max_line == 16'd0) ? slsc_pkg::DEF_MAX_LINE : max_line;
  assign tabs_on = rule_enable[slsc_pkg::RULE_TABS];

  // Build the line report
  always_comb begin
    keep    = (st.line_length > st.space_run_length) ?
              st.line_length - st.space_run_length : '0;
    trail   = rule_enable[slsc_pkg::RULE_TRAILING] && (st.space_run_length != '0);
    tcol_w  = trail ? W17'(keep) + W17'(1) : '0;
    ltabs   = (tabs_on && st.content_seen) ? st.leading_tabs : '0;
    tabs    = (tabs_on && st.content_seen) ? st.committed_tabs : '0;
    mis     = rule_enable[slsc_pkg::RULE_INDENT] && st.content_seen &&
              (st.leading_length != '0) && (st.indent_residue != 5'd0);
    len_w   = W16'(st.line_length);
    maxl_w  = W16'(maxl);
    longl   = rule_enable[slsc_pkg::RULE_LENGTH] && (len_w > maxl_w);
    sum_w   = WS'(trail) + WS'(ltabs) + WS'(mis) + WS'(tabs) + WS'(longl);
    sum     = (sum_w > WS'(slsc_pkg::LINE_ISSUES_MAX)) ?
              slsc_pkg::LINE_ISSUES_MAX : sum_w[17:0];
    total_w = {1'b0, issue_total} + 33'(sum);
    issue_total_next = total_w[32] ? 32'hFFFF_FFFF : total_w[31:0];
    ltabs_w = W16'(ltabs);
    tabs_w  = W16'(tabs);
    line_w  = WL'(line_count);

    report.line_number       = line_w[19:0];
    report.trailing_found    = trail;
    report.trailing_column   = tcol_w[16:0];
    report.leading_tab_count = ltabs_w[15:0];
    report.indent_misaligned = mis;
    report.tab_count         = tabs_w[15:0];
    report.line_too_long     = longl;
    report.line_issues       = sum;
    report.total_issues      = issue_total_next;
    report.final_line        = s1_word.text_end;
  end

  // Advance the line state by one character, releasing a held carriage return
  always_comb begin
    st_cr = st;
    if (st.pending_return) begin
      st_cr = take_char(st, slsc_pkg::CHAR_CR, width);
      st_cr.pending_return = 1'b0;
    end
    if (s1_word.text_byte == slsc_pkg::CHAR_CR) begin
      st_next = st_cr;
      st_next.pending_return = 1'b1;
    end else begin
      st_next = take_char(st_cr, s1_word.text_byte, width);
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      rule_enable   <= slsc_pkg::RULE_ENABLE_RST;
      indent_spaces <= slsc_pkg::DEF_INDENT;
      max_line      <= slsc_pkg::DEF_MAX_LINE;
    end else if (cfg_write) begin
      case (slsc_pkg::cfg_index_t'(cfg_index))
        slsc_pkg::CFG_RULE_ENABLE:   rule_enable   <= cfg_data[3:0];
        slsc_pkg::CFG_INDENT_SPACES: indent_spaces <= cfg_data[4:0];
        slsc_pkg::CFG_MAX_LINE:      max_line      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Input register: hold a word until it is processed
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_word <= in_data;
    end
  end

  // Line state, counters and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= '0;
      line_count  <= LB'(1);
      issue_total <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (fire && s1_closes) begin
        st          <= '0;
        issue_total <= issue_total_next;
        if (s1_word.text_end) begin
          line_count <= LB'(1);
        end else if (line_count != '1) begin
          line_count <= line_count + LB'(1);
        end
      end else if (fire) begin
        st <= st_next;
      end
      if (fire && s1_closes) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (fire && s1_closes) begin
      out_data <= report;
    end
  end

  // A processed closing word always leaves a report
  `SLSC_ASSERT_NEXT(a_close_reports, fire && s1_closes, out_valid)
  // A closing word never overwrites an unread report
  `SLSC_ASSERT_NOW(a_no_overwrite, out_valid && !out_ready && s1_valid && s1_closes, !fire)
  // End of text restarts line numbering
  `SLSC_ASSERT_NEXT(a_end_restarts, fire && s1_word.text_end, line_count == LB'(1))
  // The running total covers the issues of the line just reported
  `SLSC_ASSERT_NOW(a_total_covers, out_valid,
                   out_data.total_issues >= 32'(out_data.line_issues))

endmodule
